@@ design/grid_reachability_search_unit_defines.svh @@
// assertion macros for the grid reachability search checker
`ifndef GRID_REACHABILITY_SEARCH_UNIT_DEFINES_SVH
`define GRID_REACHABILITY_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define GRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grs check failed");

// next-cycle implication, off while reset is asserted
`define GRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grs check failed");

`endif

@@ design/grs_pkg.sv @@
// shared constants, types and helpers for the grid reachability search unit
`default_nettype none

package grs_pkg;

  // grid store size
  localparam int unsigned MAX_COLS = 64;
  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned COL_W    = $clog2(MAX_COLS);
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);
  localparam int unsigned CELL_W   = COL_W + ROW_W;
  localparam int unsigned CELL_N   = 1 << CELL_W;
  localparam int unsigned QPTR_W   = CELL_W + 1;

  // field and coordinate widths
  localparam int unsigned POS_W      = 6;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  // cell map word: wall bit and visited bit
  localparam int unsigned MAP_W    = 2;
  localparam int unsigned MAP_WALL = 0;
  localparam int unsigned MAP_VIS  = 1;
  localparam logic [MAP_W-1:0] MASK_ALL = 2'b11;
  localparam logic [MAP_W-1:0] MASK_VIS = 2'b10;
  localparam logic [MAP_W-1:0] WORD_VIS = 2'b10;
  localparam logic [MAP_W-1:0] WORD_CLR = 2'b00;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_START_COL   = 3'd2,
    REG_START_ROW   = 3'd3,
    REG_GOAL_COL    = 3'd4,
    REG_GOAL_ROW    = 3'd5
  } cfg_reg_e;

  // input item kinds
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_SOLVE = 1'b1
  } kind_e;

  // grid coordinate, wide enough to hold one step past either edge
  typedef struct packed {
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
  } coord_t;

  // cell map write port
  typedef struct packed {
    logic              en;
    logic [MAP_W-1:0]  mask;
    logic [CELL_W-1:0] addr;
    logic [MAP_W-1:0]  data;
  } map_wr_t;

  // frontier queue write port
  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } q_wr_t;

  // cell address as row and column bit fields
  function automatic logic [CELL_W-1:0] cell_addr(input coord_t p);
    cell_addr = {p.row[ROW_W-1:0], p.col[COL_W-1:0]};
  endfunction

endpackage

`default_nettype wire

@@ design/grs_cell_map.sv @@
// wall and visited bit store, one word per cell, masked write and registered read
`default_nettype none

module grs_cell_map (
  input  wire logic                          clk_i,
  input  wire grs_pkg::map_wr_t              wr_i,
  input  wire logic [grs_pkg::CELL_W-1:0]    rd_addr_i,
  output logic      [grs_pkg::MAP_W-1:0]     rd_data_o
);

  logic [grs_pkg::MAP_W-1:0] mem_q [grs_pkg::CELL_N];
  logic [grs_pkg::MAP_W-1:0] rd_data_q;

  // masked bit write
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      for (int b = 0; b < grs_pkg::MAP_W; b++) begin
        if (wr_i.mask[b]) begin
          mem_q[wr_i.addr][b] <= wr_i.data[b];
        end
      end
    end
  end

  // synchronous read, registered
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ design/grs_frontier_q.sv @@
// frontier queue store of cell addresses, one write and one registered read
`default_nettype none

module grs_frontier_q (
  input  wire logic                          clk_i,
  input  wire grs_pkg::q_wr_t                wr_i,
  input  wire logic [grs_pkg::CELL_W-1:0]    rd_addr_i,
  output logic      [grs_pkg::CELL_W-1:0]    rd_data_o
);

  logic [grs_pkg::CELL_W-1:0] mem_q [grs_pkg::CELL_N];
  logic [grs_pkg::CELL_W-1:0] rd_data_q;

  // push at the tail
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // pop read, registered
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ design/grid_reachability_search_unit.sv @@
// top level of the grid reachability search unit: sequencer, registers and stores
`default_nettype none

// Load items write one wall bit and are taken one per cycle. A solve item runs a
// breadth-first flood out of two stores, each with one write and one registered read
// port: the cell map (wall and visited bits) and the frontier queue. Each expanded
// cell is popped, its four neighbours are read from the cell map, the goal is checked
// and its open unvisited neighbours are marked and pushed; the solve then clears the
// visited bits it set, the start cell's and each queued cell's. One result per solve
// is held in an output register; while it is held back by the result side no item
// is taken. After reset the cell map is swept clear, one cell per cycle over all 4096
// cells, during which no item is taken (configuration writes are taken at any time).
module grid_reachability_search_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input items
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              kind_i,
  input  wire logic [grs_pkg::POS_W-1:0]         cell_col_i,
  input  wire logic [grs_pkg::POS_W-1:0]         cell_row_i,
  input  wire logic                              is_wall_i,
  // result items
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   reachable_o,
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [grs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [grs_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned DIM_W  = grs_pkg::DIM_W;
  localparam int unsigned CELL_W = grs_pkg::CELL_W;
  localparam int unsigned QPTR_W = grs_pkg::QPTR_W;

  typedef enum logic [8:0] {
    ST_CLEAR     = 9'b000000001,
    ST_IDLE      = 9'b000000010,
    ST_READ      = 9'b000000100,
    ST_CHECK     = 9'b000001000,
    ST_ENQ       = 9'b000010000,
    ST_POP       = 9'b000100000,
    ST_POP_WAIT  = 9'b001000000,
    ST_CLR_START = 9'b010000000,
    ST_CLR_QUEUE = 9'b100000000
  } state_e;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  // neighbour one step away; a step off the low edge wraps far outside the grid
  function automatic grs_pkg::coord_t nbr(input grs_pkg::coord_t p, input dir_e d);
    grs_pkg::coord_t n;
    n = p;
    case (d)
      DIR_LEFT:  n.col = p.col - DIM_W'(1);
      DIR_RIGHT: n.col = p.col + DIM_W'(1);
      DIR_UP:    n.row = p.row - DIM_W'(1);
      DIR_DOWN:  n.row = p.row + DIM_W'(1);
      default:   n = p;
    endcase
    nbr = n;
  endfunction

  function automatic logic in_grid(input grs_pkg::coord_t p,
                                   input logic [DIM_W-1:0] w,
                                   input logic [DIM_W-1:0] h);
    in_grid = (p.col < w) && (p.row < h);
  endfunction

  // configuration registers
  logic [DIM_W-1:0]          width_q, height_q;
  logic [grs_pkg::POS_W-1:0] start_col_q, start_row_q, goal_col_q, goal_row_q;

  // control registers
  state_e               state_q, state_d;
  logic [CELL_W-1:0]    clr_addr_q, clr_addr_d;
  logic [2:0]           k_q, k_d;
  logic [QPTR_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic                 out_valid_q, out_valid_d;

  // payload registers
  grs_pkg::coord_t      cur_q, cur_d;
  logic                 rd_in_q, rd_in_d;
  logic [3:0]           nb_open_q, nb_open_d, nb_vis_q, nb_vis_d;
  logic                 reach_q, reach_d;

  // store ports
  grs_pkg::map_wr_t            map_wr;
  logic [CELL_W-1:0]           map_rd_addr;
  logic [grs_pkg::MAP_W-1:0]   map_rd_data;
  grs_pkg::q_wr_t              q_wr;
  logic [CELL_W-1:0]           q_rd_addr;
  logic [CELL_W-1:0]           q_rd_data;

  logic [DIM_W-1:0]     eff_w, eff_h;
  grs_pkg::coord_t      start_pos, load_pos, goal_pos, nb_pos;
  logic                 in_accept, goal_hit;
  logic [1:0]           cap_idx;

  grs_cell_map u_cell_map (
    .clk_i     (clk_i),
    .wr_i      (map_wr),
    .rd_addr_i (map_rd_addr),
    .rd_data_o (map_rd_data)
  );

  grs_frontier_q u_frontier_q (
    .clk_i     (clk_i),
    .wr_i      (q_wr),
    .rd_addr_i (q_rd_addr),
    .rd_data_o (q_rd_data)
  );

  // grid size limited to the store
  assign eff_w = (width_q > DIM_W'(grs_pkg::MAX_COLS)) ? DIM_W'(grs_pkg::MAX_COLS) : width_q;
  assign eff_h = (height_q > DIM_W'(grs_pkg::MAX_ROWS)) ? DIM_W'(grs_pkg::MAX_ROWS) : height_q;

  assign start_pos = '{col: DIM_W'(start_col_q), row: DIM_W'(start_row_q)};
  assign goal_pos  = '{col: DIM_W'(goal_col_q),  row: DIM_W'(goal_row_q)};
  assign load_pos  = '{col: DIM_W'(cell_col_i),  row: DIM_W'(cell_row_i)};

  // handshakes
  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign reachable_o = reach_q;

  // goal is an open neighbour of the current cell
  always_comb begin
    goal_hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (nb_open_q[i] && (nbr(cur_q, dir_e'(i[1:0])) == goal_pos)) begin
        goal_hit = 1'b1;
      end
    end
  end

  assign nb_pos  = nbr(cur_q, dir_e'(k_q[1:0]));
  assign cap_idx = k_q[1:0] - 2'd1;

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    k_d         = k_q;
    head_d      = head_q;
    tail_d      = tail_q;
    out_valid_d = out_valid_q && out_stall_i;
    cur_d       = cur_q;
    rd_in_d     = rd_in_q;
    nb_open_d   = nb_open_q;
    nb_vis_d    = nb_vis_q;
    reach_d     = reach_q;
    map_wr      = '0;
    map_rd_addr = grs_pkg::cell_addr(nb_pos);
    q_wr        = '0;
    q_rd_addr   = head_q[CELL_W-1:0];

    case (state_q)
      // sweep the cell map clear after reset
      ST_CLEAR: begin
        map_wr = '{en: 1'b1, mask: grs_pkg::MASK_ALL, addr: clr_addr_q,
                   data: grs_pkg::WORD_CLR};
        clr_addr_d = clr_addr_q + CELL_W'(1);
        if (&clr_addr_q) begin
          state_d = ST_IDLE;
        end
      end
      // take loads and solves
      ST_IDLE: begin
        if (in_accept) begin
          if (grs_pkg::kind_e'(kind_i) == grs_pkg::KIND_LOAD) begin
            if (in_grid(load_pos, eff_w, eff_h)) begin
              map_wr = '{en: 1'b1, mask: grs_pkg::MASK_ALL,
                         addr: grs_pkg::cell_addr(load_pos),
                         data: {1'b0, is_wall_i}};
            end
          end else begin
            if (in_grid(start_pos, eff_w, eff_h)) begin
              map_wr = '{en: 1'b1, mask: grs_pkg::MASK_VIS,
                         addr: grs_pkg::cell_addr(start_pos),
                         data: grs_pkg::WORD_VIS};
            end
            cur_d   = start_pos;
            k_d     = '0;
            head_d  = '0;
            tail_d  = '0;
            state_d = ST_READ;
          end
        end
      end
      // read four neighbours, capture each in the cycle after its read
      ST_READ: begin
        if (!k_q[2]) begin
          rd_in_d = in_grid(nb_pos, eff_w, eff_h);
        end
        if (k_q != 3'd0) begin
          nb_open_d[cap_idx] = rd_in_q && !map_rd_data[grs_pkg::MAP_WALL];
          nb_vis_d[cap_idx]  = map_rd_data[grs_pkg::MAP_VIS];
        end
        if (k_q[2]) begin
          k_d     = '0;
          state_d = ST_CHECK;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      // goal test before any push
      ST_CHECK: begin
        if (goal_hit) begin
          out_valid_d = 1'b1;
          reach_d     = 1'b1;
          state_d     = ST_CLR_START;
        end else begin
          state_d = ST_ENQ;
        end
      end
      // mark and push open unvisited neighbours
      ST_ENQ: begin
        if (nb_open_q[k_q[1:0]] && !nb_vis_q[k_q[1:0]]) begin
          map_wr = '{en: 1'b1, mask: grs_pkg::MASK_VIS,
                     addr: grs_pkg::cell_addr(nb_pos), data: grs_pkg::WORD_VIS};
          q_wr   = '{en: 1'b1, addr: tail_q[CELL_W-1:0],
                     data: grs_pkg::cell_addr(nb_pos)};
          tail_d = tail_q + QPTR_W'(1);
        end
        if (k_q[1:0] == 2'd3) begin
          state_d = ST_POP;
        end
        k_d = k_q + 3'd1;
      end
      // next cell from the queue, or give up when empty
      ST_POP: begin
        if (head_q == tail_q) begin
          out_valid_d = 1'b1;
          reach_d     = 1'b0;
          state_d     = ST_CLR_START;
        end else begin
          head_d  = head_q + QPTR_W'(1);
          state_d = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        cur_d.col = DIM_W'(q_rd_data[grs_pkg::COL_W-1:0]);
        cur_d.row = DIM_W'(q_rd_data[CELL_W-1:grs_pkg::COL_W]);
        k_d       = '0;
        state_d   = ST_READ;
      end
      // clear the start cell's visited bit
      ST_CLR_START: begin
        if (in_grid(start_pos, eff_w, eff_h)) begin
          map_wr = '{en: 1'b1, mask: grs_pkg::MASK_VIS,
                     addr: grs_pkg::cell_addr(start_pos), data: grs_pkg::WORD_CLR};
        end
        head_d  = '0;
        state_d = ST_CLR_QUEUE;
      end
      // walk the queue, clearing each pushed cell in the cycle after its read
      ST_CLR_QUEUE: begin
        if (head_q != QPTR_W'(0)) begin
          map_wr = '{en: 1'b1, mask: grs_pkg::MASK_VIS, addr: q_rd_data,
                     data: grs_pkg::WORD_CLR};
        end
        if (head_q == tail_q) begin
          head_d  = '0;
          tail_d  = '0;
          state_d = ST_IDLE;
        end else begin
          head_d = head_q + QPTR_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= DIM_W'(64);
      height_q    <= DIM_W'(64);
      start_col_q <= '0;
      start_row_q <= '0;
      goal_col_q  <= '1;
      goal_row_q  <= '1;
    end else if (cfg_we_i) begin
      case (grs_pkg::cfg_reg_e'(cfg_index_i))
        grs_pkg::REG_GRID_WIDTH:  width_q     <= cfg_data_i;
        grs_pkg::REG_GRID_HEIGHT: height_q    <= cfg_data_i;
        grs_pkg::REG_START_COL:   start_col_q <= cfg_data_i[grs_pkg::POS_W-1:0];
        grs_pkg::REG_START_ROW:   start_row_q <= cfg_data_i[grs_pkg::POS_W-1:0];
        grs_pkg::REG_GOAL_COL:    goal_col_q  <= cfg_data_i[grs_pkg::POS_W-1:0];
        grs_pkg::REG_GOAL_ROW:    goal_row_q  <= cfg_data_i[grs_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      k_q         <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      k_q         <= k_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    rd_in_q   <= rd_in_d;
    nb_open_q <= nb_open_d;
    nb_vis_q  <= nb_vis_d;
    reach_q   <= reach_d;
  end

endmodule

`default_nettype wire

@@ design/grs_checker.sv @@
// port-level checks for the grid reachability search unit, bound to the top level
`default_nettype none
`include "grid_reachability_search_unit_defines.svh"

module grs_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic                              kind_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic                              reachable_o
);

  logic solve_take;

  // a solve item taken at this edge
  assign solve_take = in_valid_i && !in_stall_o &&
                      (grs_pkg::kind_e'(kind_i) == grs_pkg::KIND_SOLVE);

  // a held result stays offered and unchanged
  `GRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `GRS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(reachable_o))

  // a solve keeps the input side busy for at least the next cycle
  `GRS_ASSERT_NEXT(a_solve_busy, clk_i, rst_ni, solve_take, in_stall_o)

  // a fresh result appears only while its solve still holds the input side
  `GRS_ASSERT_NOW(a_result_busy, clk_i, rst_ni, $rose(out_valid_o), in_stall_o)

endmodule

bind grid_reachability_search_unit grs_checker u_grs_checker (.*);

`default_nettype wire
